// File: hdl/rvm_pkg.sv
`timescale 1ns / 1ps

package rvm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegAddrW = 4;
  localparam int unsigned MemBytes = 65536;
  localparam int unsigned MemAddrW = $clog2(MemBytes);
  localparam logic [DataW-1:0] IpStep = 32'd8;
  localparam logic [RegAddrW-1:0] RegFlag = 4'd0;
  localparam logic [RegAddrW-1:0] RegIp = 4'd1;
  localparam logic [RegAddrW-1:0] RegOut = 4'd15;

  localparam logic [4:0] FnEnd = 5'd0;
  localparam logic [4:0] FnNop = 5'd1;
  localparam logic [4:0] FnOut = 5'd2;
  localparam logic [4:0] FnAddI = 5'd3;
  localparam logic [4:0] FnAddR = 5'd4;
  localparam logic [4:0] FnSubI = 5'd5;
  localparam logic [4:0] FnSubR = 5'd6;
  localparam logic [4:0] FnMulI = 5'd7;
  localparam logic [4:0] FnMulR = 5'd8;
  localparam logic [4:0] FnDivI = 5'd9;
  localparam logic [4:0] FnDivR = 5'd10;
  localparam logic [4:0] FnLodI = 5'd11;
  localparam logic [4:0] FnLodR = 5'd12;
  localparam logic [4:0] FnLodRI = 5'd13;
  localparam logic [4:0] FnLodMI = 5'd14;
  localparam logic [4:0] FnLodMR = 5'd15;
  localparam logic [4:0] FnLodMRI = 5'd16;
  localparam logic [4:0] FnStoI = 5'd17;
  localparam logic [4:0] FnStoR = 5'd18;
  localparam logic [4:0] FnStoRI = 5'd19;
  localparam logic [4:0] FnStoXI = 5'd20;
  localparam logic [4:0] FnTst = 5'd21;
  localparam logic [4:0] FnJmpI = 5'd22;
  localparam logic [4:0] FnJgzR = 5'd29;
  localparam logic [4:0] FnImage = 5'd30;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StChar = 3'd1;
  localparam logic [2:0] StEnd = 3'd2;
  localparam logic [2:0] StDivZero = 3'd3;
  localparam logic [2:0] StInvalid = 3'd4;
  localparam logic [2:0] StHalted = 3'd5;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

// File: hdl/rvm_div.sv
`timescale 1ns / 1ps

// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module rvm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvm_pkg::div_req_t req_i,
  output rvm_pkg::div_rsp_t rsp_o
);
  import rvm_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q, quo_q, den_q;
  logic        neg_q;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num[31] ? (32'd0 - req_i.num) : req_i.num;
      den_q <= req_i.den[31] ? (32'd0 - req_i.den) : req_i.den;
      neg_q <= req_i.num[31] ^ req_i.den[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

// File: hdl/register_vm_execute_unit.sv
`timescale 1ns / 1ps

// Executes one decoded instruction per item on a 16 x 32-bit register file
// and a byte-wide data memory of MemBytes bytes (64 KiB), both single-port
// synchronous RAMs. After reset a clearing pass writes zero to every memory
// byte and every register, one memory byte per cycle, before the first item
// is taken. An item is taken, then the five register reads run, then it
// executes, writes back the destination and then the instruction pointer,
// and passes through the output register. A multiply goes through the wait
// state, a load reads four bytes through the one memory port, a store writes
// four, and a divide waits on the bit-serial divider. END, divide by zero,
// invalid opcodes, image byte loads and every item while halted go from
// execute straight to the output register. One result item follows each
// input item; the next input item is taken once the result has left the
// output register.
module register_vm_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0 up: func[4:0], reg_x[8:5], reg_y[12:9], immediate[44:13],
  // image_byte[52:45], zero fill.
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0 up: status[2:0], out_char[10:3], next_ip[42:11], zero fill.
  output logic [47:0] m_axis_tdata
);
  import rvm_pkg::*;

  localparam int unsigned AW = MemAddrW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_MRD, S_MWR, S_WB, S_OUT
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic [4:0]  fn_q;
  logic [3:0]  rx_q, ry_q;
  logic [31:0] imm_q, vx_q, vy_q, flag_q, ip_q, r15_q, word_q, wbv_q;
  logic [7:0]  byte_q;
  logic [1:0]  k_q;
  logic [31:0] addr_q;
  logic        halted_q, wbe_q, jump_q;
  logic [2:0]  status_q;
  logic [7:0]  ch_q;
  logic [2:0]  rcnt_q;

  // register file
  logic [31:0] rf [16];
  logic        rf_we;
  logic [3:0]  rf_addr;
  logic [31:0] rf_wd, rf_rd;
  always_ff @(posedge clk_i) begin
    if (rf_we) rf[rf_addr] <= rf_wd;
    rf_rd <= rf[rf_addr];
  end

  // data memory
  logic [7:0]  mem [MemBytes];
  logic        m_we;
  logic [AW-1:0] m_addr;
  logic [7:0]  m_wd, m_rd;
  always_ff @(posedge clk_i) begin
    if (m_we) mem[m_addr] <= m_wd;
    m_rd <= mem[m_addr];
  end

  div_req_t dreq;
  div_rsp_t drsp;
  rvm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [31:0] mul_q;

  // register reads: x, y, flag, ip, r15 in order
  always_comb begin
    rf_we = 1'b0;
    rf_wd = wbv_q;
    rf_addr = rx_q;
    case (state_q)
      S_CLR: begin
        rf_we = 1'b1;
        rf_addr = clr_q[3:0];
        rf_wd = '0;
      end
      S_RD1: begin
        case (rcnt_q)
          3'd0: rf_addr = rx_q;
          3'd1: rf_addr = ry_q;
          3'd2: rf_addr = RegFlag;
          3'd3: rf_addr = RegIp;
          default: rf_addr = RegOut;
        endcase
      end
      S_WB: begin
        rf_we = (rcnt_q == 3'd0) ? wbe_q : 1'b1;
        rf_addr = (rcnt_q == 3'd0) ? rx_q : RegIp;
        rf_wd = wbv_q;
      end
      default: ;
    endcase
  end

  logic [31:0] byte_addr;
  assign byte_addr = addr_q + {30'd0, k_q};
  always_comb begin
    m_we = 1'b0;
    m_wd = '0;
    m_addr = byte_addr[AW-1:0];
    case (state_q)
      S_CLR: begin
        m_we = 1'b1;
        m_addr = clr_q;
      end
      S_MWR: begin
        m_we = 1'b1;
        case (k_q)
          2'd0: m_wd = word_q[31:24];
          2'd1: m_wd = word_q[23:16];
          2'd2: m_wd = word_q[15:8];
          default: m_wd = word_q[7:0];
        endcase
      end
      S_EXEC: begin
        m_we = (fn_q == FnImage) && !halted_q;
        m_addr = imm_q[AW-1:0];
        m_wd = byte_q;
      end
      default: ;
    endcase
  end

  assign dreq.start = (state_q == S_EXEC) && !halted_q
                      && (fn_q == FnDivI || fn_q == FnDivR)
                      && ((fn_q == FnDivI ? imm_q : vy_q) != 32'd0);
  assign dreq.num = vx_q;
  assign dreq.den = (fn_q == FnDivI) ? imm_q : vy_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {5'd0, ip_q, ch_q, status_q};

  logic [31:0] ip_adv;
  logic        take;
  logic [31:0] kind;
  assign ip_adv = ip_q + IpStep;
  assign kind = ({27'd0, fn_q} - {27'd0, FnJmpI}) >> 1;
  assign take = (kind == 32'd0) || (flag_q == kind - 32'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      halted_q <= 1'b0;
      rcnt_q <= '0;
      k_q <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MemBytes - 1)) begin
            state_q <= S_IDLE;
            rcnt_q <= '0;
          end
        end
        S_IDLE: if (s_axis_tvalid) begin
          fn_q <= s_axis_tdata[4:0];
          rx_q <= s_axis_tdata[8:5];
          ry_q <= s_axis_tdata[12:9];
          imm_q <= s_axis_tdata[44:13];
          byte_q <= s_axis_tdata[52:45];
          rcnt_q <= '0;
          state_q <= S_RD1;
        end
        S_RD1: begin
          rcnt_q <= rcnt_q + 3'd1;
          state_q <= S_RD2;
        end
        S_RD2: begin
          case (rcnt_q)
            3'd1: vx_q <= rf_rd;
            3'd2: vy_q <= rf_rd;
            3'd3: flag_q <= rf_rd;
            3'd4: ip_q <= rf_rd;
            default: r15_q <= rf_rd;
          endcase
          state_q <= (rcnt_q == 3'd5) ? S_EXEC : S_RD1;
        end
        S_EXEC: begin
          wbe_q <= 1'b0;
          jump_q <= 1'b0;
          status_q <= StOk;
          ch_q <= '0;
          k_q <= '0;
          rcnt_q <= '0;
          mul_q <= vx_q * ((fn_q == FnMulI) ? imm_q : vy_q);
          state_q <= S_WB;
          if (halted_q) begin
            status_q <= StHalted;
            state_q <= S_OUT;
          end else begin
            case (fn_q)
              FnEnd: begin
                status_q <= StEnd; halted_q <= 1'b1; state_q <= S_OUT;
              end
              FnNop: ;
              FnOut: begin status_q <= StChar; ch_q <= r15_q[7:0]; end
              FnAddI: begin wbe_q <= 1'b1; wbv_q <= vx_q + imm_q; end
              FnAddR: begin wbe_q <= 1'b1; wbv_q <= vx_q + vy_q; end
              FnSubI: begin wbe_q <= 1'b1; wbv_q <= vx_q - imm_q; end
              FnSubR: begin wbe_q <= 1'b1; wbv_q <= vx_q - vy_q; end
              FnMulI, FnMulR: begin wbe_q <= 1'b1; state_q <= S_DIV; end
              FnDivI, FnDivR: begin
                if (!dreq.start) begin
                  status_q <= StDivZero; halted_q <= 1'b1; state_q <= S_OUT;
                end else begin
                  wbe_q <= 1'b1; state_q <= S_DIV;
                end
              end
              FnLodI: begin wbe_q <= 1'b1; wbv_q <= imm_q; end
              FnLodR: begin wbe_q <= 1'b1; wbv_q <= vy_q; end
              FnLodRI: begin wbe_q <= 1'b1; wbv_q <= vy_q + imm_q; end
              FnLodMI: begin addr_q <= imm_q; wbe_q <= 1'b1; state_q <= S_MRD; end
              FnLodMR: begin addr_q <= vy_q; wbe_q <= 1'b1; state_q <= S_MRD; end
              FnLodMRI: begin
                addr_q <= vy_q + imm_q; wbe_q <= 1'b1; state_q <= S_MRD;
              end
              FnStoI: begin addr_q <= vx_q; word_q <= imm_q; state_q <= S_MWR; end
              FnStoR: begin addr_q <= vx_q; word_q <= vy_q; state_q <= S_MWR; end
              FnStoRI: begin
                addr_q <= vx_q; word_q <= vy_q + imm_q; state_q <= S_MWR;
              end
              FnStoXI: begin
                addr_q <= vx_q + imm_q; word_q <= vy_q; state_q <= S_MWR;
              end
              FnTst: begin
                wbe_q <= 1'b1;
                rx_q <= RegFlag;
                wbv_q <= (vx_q == 32'd0) ? 32'd0 : (vx_q[31] ? 32'd1 : 32'd2);
              end
              FnImage: state_q <= S_OUT;
              default: begin
                if (fn_q >= FnJmpI && fn_q <= FnJgzR) begin
                  jump_q <= take;
                  word_q <= fn_q[0] ? vx_q : imm_q;
                end else begin
                  status_q <= StInvalid; halted_q <= 1'b1; state_q <= S_OUT;
                end
              end
            endcase
          end
        end
        S_DIV: begin
          // shared wait state for the multiplier register and the divider
          if (fn_q == FnMulI || fn_q == FnMulR) begin
            wbv_q <= mul_q;
            state_q <= S_WB;
          end else if (drsp.done) begin
            wbv_q <= drsp.quot;
            state_q <= S_WB;
          end
        end
        S_MRD: begin
          // the read of byte k returns while byte k+1 is addressed
          k_q <= k_q + 2'd1;
          rcnt_q <= rcnt_q + 3'd1;
          if (rcnt_q != 3'd0) wbv_q <= {wbv_q[23:0], m_rd};
          if (rcnt_q == 3'd4) begin
            rcnt_q <= '0;
            state_q <= S_WB;
          end
        end
        S_MWR: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) state_q <= S_WB;
        end
        S_WB: begin
          // first the destination, then the instruction pointer
          if (rcnt_q == 3'd0) begin
            rcnt_q <= 3'd1;
            if (jump_q) wbv_q <= word_q;
            else if (wbe_q && rx_q == RegIp) wbv_q <= wbv_q + IpStep;
            else wbv_q <= ip_adv;
          end else begin
            ip_q <= wbv_q;
            state_q <= S_OUT;
          end
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  property p_halt_status;
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && halted_q) |=> (status_q == StHalted);
  endproperty
  a_halt_status: assert property (p_halt_status) else $error("halted item not flagged");

  property p_no_mem_write_halted;
    @(posedge clk_i) disable iff (!rst_ni)
    (m_we && state_q != S_CLR) |-> !halted_q || state_q == S_MWR;
  endproperty
  a_no_mem_write_halted: assert property (p_no_mem_write_halted)
    else $error("memory written while halted");

  property p_div_start_exec;
    @(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> (dreq.den != 32'd0);
  endproperty
  a_div_start_exec: assert property (p_div_start_exec) else $error("divide by zero started");

endmodule

// File: tb/register_vm_execute_unit_tb.sv
`timescale 1ns / 1ps

module register_vm_execute_unit_tb;
  import rvm_pkg::*;

  // Codes that the package does not name.
  localparam logic [4:0] FnJmpR = 5'd23;
  localparam logic [4:0] FnJezI = 5'd24;
  localparam logic [4:0] FnJezR = 5'd25;
  localparam logic [4:0] FnJlzI = 5'd26;
  localparam logic [4:0] FnJlzR = 5'd27;
  localparam logic [4:0] FnJgzI = 5'd28;
  localparam logic [4:0] FnBad = 5'd31;

  localparam int unsigned NumRandom = 1620;
  localparam int unsigned QuietTail = 200;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [4:0]  fn;
    logic [3:0]  rx;
    logic [3:0]  ry;
    logic [31:0] imm;
    logic [7:0]  byte_val;
    logic        typed;
    logic [2:0]  st;
  } instr_t;

  // Packed so that status sits in the lowest bits, as on the result bus.
  typedef struct packed {
    logic [31:0] next_ip;
    logic [7:0]  out_char;
    logic [2:0]  status;
  } retire_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  logic [31:0] regs [16];
  logic [7:0]  mem [65536];
  logic        halted_q;
  retire_t     retire_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet;
  int unsigned stall_left = 0;

  register_vm_execute_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] read_word(input logic [31:0] a);
    return {mem[16'(a)], mem[16'(a + 1)], mem[16'(a + 2)], mem[16'(a + 3)]};
  endfunction

  function automatic void write_word(input logic [31:0] a, input logic [31:0] v);
    mem[16'(a)]     = v[31:24];
    mem[16'(a + 1)] = v[23:16];
    mem[16'(a + 2)] = v[15:8];
    mem[16'(a + 3)] = v[7:0];
  endfunction

  function automatic logic [31:0] quotient(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] nm;
    logic [31:0] dm;
    logic [31:0] q;
    nm = n[31] ? -n : n;
    dm = d[31] ? -d : d;
    q = nm / dm;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic retire_t execute_instr(input instr_t it);
    retire_t     r;
    logic        adv;
    logic        jmp;
    logic [31:0] tgt;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] flag;
    logic [31:0] dv;
    int unsigned kind;
    r = '0;
    adv = 1'b1;
    jmp = 1'b0;
    tgt = '0;
    vx = regs[it.rx];
    vy = regs[it.ry];
    flag = regs[RegFlag];
    if (halted_q) begin
      r.status = StHalted;
      adv = 1'b0;
    end else begin
      case (it.fn)
        FnEnd: begin
          r.status = StEnd;
          halted_q = 1'b1;
          adv = 1'b0;
        end
        FnNop: ;
        FnOut: begin
          r.status = StChar;
          r.out_char = regs[RegOut][7:0];
        end
        FnAddI: regs[it.rx] = vx + it.imm;
        FnAddR: regs[it.rx] = vx + vy;
        FnSubI: regs[it.rx] = vx - it.imm;
        FnSubR: regs[it.rx] = vx - vy;
        FnMulI: regs[it.rx] = vx * it.imm;
        FnMulR: regs[it.rx] = vx * vy;
        FnDivI, FnDivR: begin
          dv = (it.fn == FnDivI) ? it.imm : vy;
          if (dv == 0) begin
            r.status = StDivZero;
            halted_q = 1'b1;
            adv = 1'b0;
          end else begin
            regs[it.rx] = quotient(vx, dv);
          end
        end
        FnLodI: regs[it.rx] = it.imm;
        FnLodR: regs[it.rx] = vy;
        FnLodRI: regs[it.rx] = vy + it.imm;
        FnLodMI: regs[it.rx] = read_word(it.imm);
        FnLodMR: regs[it.rx] = read_word(vy);
        FnLodMRI: regs[it.rx] = read_word(vy + it.imm);
        FnStoI: write_word(vx, it.imm);
        FnStoR: write_word(vx, vy);
        FnStoRI: write_word(vx, vy + it.imm);
        FnStoXI: write_word(vx + it.imm, vy);
        FnTst: regs[RegFlag] = (vx == 0) ? 32'd0 : (vx[31] ? 32'd1 : 32'd2);
        FnJmpI, FnJmpR, FnJezI, FnJezR, FnJlzI, FnJlzR, FnJgzI, FnJgzR: begin
          kind = (it.fn - FnJmpI) >> 1;
          if (kind == 0 || flag == kind - 1) begin
            jmp = 1'b1;
            tgt = it.fn[0] ? vx : it.imm;
          end
        end
        FnImage: begin
          mem[16'(it.imm)] = it.byte_val;
          adv = 1'b0;
        end
        default: begin
          r.status = StInvalid;
          halted_q = 1'b1;
          adv = 1'b0;
        end
      endcase
    end
    if (jmp) regs[RegIp] = tgt;
    else if (adv) regs[RegIp] = regs[RegIp] + IpStep;
    r.next_ip = regs[RegIp];
    return r;
  endfunction

  function automatic instr_t mk(input logic [4:0] fn, input logic [3:0] rx,
                                input logic [3:0] ry, input logic [31:0] imm,
                                input logic [7:0] b = 8'h00, input logic typed = 1'b0,
                                input logic [2:0] st = StOk);
    instr_t it;
    it = '{fn, rx, ry, imm, b, typed, st};
    return it;
  endfunction

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(5))
      0: return $urandom_range(64);
      1: return -$urandom_range(64);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      3: return $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    it = mk(5'($urandom_range(FnNop, FnImage)), 4'($urandom), 4'($urandom),
            rand_imm(), 8'($urandom));
    // Divides stay clear of zero so the block does not halt mid-run.
    if (it.fn == FnDivR && regs[it.ry] == 0) it.fn = FnDivI;
    if (it.fn == FnDivI && it.imm == 0) it.imm = 32'd1;
    return it;
  endfunction

  task automatic send(input instr_t it);
    retire_t r;
    if (!quiet && $urandom_range(7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.byte_val, it.imm, it.ry, it.rx, it.fn};
    do @(posedge clk_i); while (!s_axis_tready);
    r = execute_instr(it);
    if (it.typed) r.status = it.st;
    retire_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("register_vm_execute_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver stalls in bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    retire_t got;
    retire_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[42:0];
      if (retire_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        errors++;
      end else begin
        want = retire_q.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.out_char !== want.out_char) begin
          $display("%0t: out_char expected %h actual %h", $time, want.out_char,
                   got.out_char);
          errors++;
        end
        if (got.next_ip !== want.next_ip) begin
          $display("%0t: next_ip expected %h actual %h", $time, want.next_ip, got.next_ip);
          errors++;
        end
      end
    end
  end

  initial begin
    instr_t dir [$];
    int unsigned k;
    quiet = 1'b0;
    halted_q = 1'b0;
    foreach (regs[i]) regs[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir = '{
      mk(FnNop, 4'd0, 4'd0, 32'd0),
      mk(FnLodI, 4'd2, 4'd0, 32'h7fffffff),
      mk(FnLodI, 4'd3, 4'd0, 32'h80000000),
      mk(FnLodI, 4'd4, 4'd0, 32'hffffffff),
      mk(FnAddI, 4'd2, 4'd0, 32'd1),
      mk(FnAddR, 4'd4, 4'd4, 32'd0),
      mk(FnSubI, 4'd3, 4'd0, 32'd1),
      mk(FnSubR, 4'd5, 4'd2, 32'd0),
      mk(FnMulI, 4'd4, 4'd0, 32'hfffffffd),
      mk(FnMulR, 4'd4, 4'd4, 32'd0),
      mk(FnLodI, 4'd6, 4'd0, 32'h80000000),
      mk(FnDivI, 4'd6, 4'd0, 32'hffffffff),
      mk(FnDivR, 4'd4, 4'd5, 32'd0),
      mk(FnLodI, 4'd7, 4'd0, 32'h0000fffe),
      mk(FnStoI, 4'd7, 4'd0, 32'h11223344),
      mk(FnLodMI, 4'd8, 4'd0, 32'hfffffffe),
      mk(FnLodR, 4'd9, 4'd7, 32'd0),
      mk(FnLodRI, 4'd10, 4'd7, 32'd3),
      mk(FnLodMR, 4'd11, 4'd7, 32'd0),
      mk(FnLodMRI, 4'd12, 4'd7, 32'hffff0001),
      mk(FnStoR, 4'd7, 4'd3, 32'd0),
      mk(FnStoRI, 4'd9, 4'd4, 32'd2),
      mk(FnStoXI, 4'd7, 4'd2, 32'hffffffff),
      mk(FnImage, 4'd0, 4'd0, 32'hffffffff, 8'hff),
      mk(FnLodI, 4'd15, 4'd0, 32'h000001a5),
      mk(FnOut, 4'd0, 4'd0, 32'd0, 8'h00, 1'b1, StChar),
      mk(FnTst, 4'd3, 4'd0, 32'd0),
      mk(FnJlzI, 4'd0, 4'd0, 32'h00001000),
      mk(FnJezR, 4'd2, 4'd0, 32'd0),
      mk(FnJgzI, 4'd0, 4'd0, 32'd0),
      mk(FnJmpR, 4'd7, 4'd0, 32'd0),
      mk(FnLodI, 4'd1, 4'd0, 32'hfffffff8)
    };
    foreach (dir[i]) send(dir[i]);

    for (k = 0; k < NumRandom; k++) begin
      if (k == NumRandom / 2) begin
        s_axis_tvalid <= 1'b0;
        while (retire_q.size() != 0) @(posedge clk_i);
      end
      if (k == NumRandom - QuietTail) quiet = 1'b1;
      send(rand_instr());
    end

    // Halting is sticky until reset, so it can only be tried once at the end.
    case ($urandom_range(2))
      0: send(mk(FnEnd, 4'd0, 4'd0, 32'd0, 8'h00, 1'b1, StEnd));
      1: send(mk(FnDivI, 4'd2, 4'd0, 32'd0, 8'h00, 1'b1, StDivZero));
      default: send(mk(FnBad, 4'd2, 4'd3, 32'd0, 8'h00, 1'b1, StInvalid));
    endcase
    send(mk(FnImage, 4'd0, 4'd0, 32'h00000010, 8'h5a, 1'b1, StHalted));
    send(mk(FnOut, 4'd0, 4'd0, 32'd0, 8'h00, 1'b1, StHalted));
    send(mk(FnLodMI, 4'd2, 4'd0, 32'h00000010, 8'h00, 1'b1, StHalted));
    s_axis_tvalid <= 1'b0;

    while (retire_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("register_vm_execute_unit_tb: done, clean");
    end else begin
      $display("register_vm_execute_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rvm_pkg.sv
hdl/rvm_div.sv
hdl/register_vm_execute_unit.sv
tb/register_vm_execute_unit_tb.sv
